// ===== sv/assert_macros.svh =====
// shared assertion macros, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define RMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rmh check failed");

// antecedent implies consequent in the next cycle
`define RMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmh check failed");

`endif

// ===== sv/rmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rmh_pkg;
  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_W          = 11;
  localparam int CAP_RESET      = 1024;
  localparam int COUNT_W        = 11;
  localparam int MED_W          = 32;
  localparam int STATUS_W       = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // out_tdata layout
  localparam int OUT_TDATA_W = 48;
endpackage
`default_nettype wire

// ===== sv/running_median_two_heaps_top.sv =====
// running median over two heaps sharing one single-port-read memory
// sequencing: a refused item goes straight to the result beat; otherwise up to one pop
//   and two pushes per insert, each walking the heap level by level through the memory
// throughput: one item at a time, set by the sift walks through the memory read port
// reset: synchronous active-low rst_n empties both heaps and sets capacity to 1024;
//   memory contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps_top #(
  parameter int DEPTH      = rmh_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rmh_pkg::DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tuser,   // [0] command
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] median, [42:32] count, [44:43] status, zero pad
  output logic             out_tuser,  // [0] median_valid
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import rmh_pkg::*;

  localparam int IW = $clog2(DEPTH);       // memory index
  localparam int CW = $clog2(DEPTH + 1);   // per-heap count
  localparam int LW = IW + 2;              // child index arithmetic
  localparam logic SIDE_LO = 1'b0;         // max-heap from entry 0
  localparam logic SIDE_UP = 1'b1;         // min-heap from the top entry

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NEXT    = 4'd1;
  localparam logic [3:0] S_PU_LOOP = 4'd2;
  localparam logic [3:0] S_PU_CMP  = 4'd3;
  localparam logic [3:0] S_PO_LAST = 4'd4;
  localparam logic [3:0] S_PO_LOOP = 4'd5;
  localparam logic [3:0] S_PO_L    = 4'd6;
  localparam logic [3:0] S_PO_R    = 4'd7;
  localparam logic [3:0] S_PO_CMP  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  typedef logic signed [DATA_WIDTH-1:0] val_t;

  // heap storage, lower heap at low addresses, upper heap mirrored from the top
  val_t           mem [DEPTH];
  val_t           rd_data_r;
  logic           mem_we, mem_re;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  val_t           mem_wdata;

  logic [3:0]     state_r;
  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]  lo_cnt_r, up_cnt_r;
  logic           need_pop_r, need_p1_r, need_p2_r;
  logic           pside_r, side_r;
  val_t           x_r, med_r, v_r, c_r, lo_top_r, up_top_r;
  logic [IW-1:0]  i_r, cidx_r;
  logic [CW-1:0]  n_r;
  logic [STATUS_W-1:0] status_r;
  logic           out_valid_r, out_mv_r;
  logic [MED_W-1:0]   out_med_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [STATUS_W-1:0] out_st_r;

  // map a heap position to a memory address
  function automatic logic [IW-1:0] heap_addr(input logic side, input logic [IW-1:0] idx);
    heap_addr = side ? (IW'(DEPTH - 1) - idx) : idx;
  endfunction

  // input value sign-adjusted to the data width
  logic signed [63:0] in_v64;
  val_t               in_x;
  assign in_v64 = 64'(signed'(in_tdata));
  assign in_x   = in_v64[DATA_WIDTH-1:0];

  // current operation helpers
  logic [CW-1:0] pcnt, pocnt, total;
  logic          full;
  logic [IW-1:0] par_idx;
  logic [LW-1:0] l_idx, r_idx;
  logic          l_in, r_in, pu_better, po_take_r, po_stay;

  assign pcnt  = pside_r ? up_cnt_r : lo_cnt_r;
  assign pocnt = pside_r ? lo_cnt_r : up_cnt_r;
  assign total = lo_cnt_r + up_cnt_r;
  assign full  = (32'(total) >= 32'(cap_r)) || (32'(total) >= 32'(DEPTH));

  assign par_idx   = (i_r - IW'(1)) >> 1;
  assign l_idx     = (LW'(i_r) << 1) + LW'(1);
  assign r_idx     = l_idx + LW'(1);
  assign l_in      = l_idx < LW'(n_r);
  assign r_in      = r_idx < LW'(n_r);
  // sift-up: move the hole up while the new value beats its parent
  assign pu_better = side_r ? (v_r < rd_data_r) : (v_r > rd_data_r);
  // sift-down: left child wins ties
  assign po_take_r = side_r ? (c_r > rd_data_r) : (c_r < rd_data_r);
  assign po_stay   = side_r ? (v_r <= c_r) : (v_r >= c_r);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = heap_addr(side_r, i_r);
    mem_raddr = heap_addr(side_r, i_r);
    mem_wdata = v_r;
    case (state_r)
      S_NEXT: begin
        // fetch the last element of the heap being popped
        mem_re    = need_pop_r && (pcnt > CW'(1));
        mem_raddr = heap_addr(pside_r, IW'(pcnt - CW'(1)));
      end
      S_PU_LOOP: begin
        if (i_r == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = heap_addr(side_r, par_idx);
        end
      end
      S_PU_CMP: begin
        mem_we = 1'b1;
        if (pu_better) mem_wdata = rd_data_r;
      end
      S_PO_LOOP: begin
        if (!l_in) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = heap_addr(side_r, l_idx[IW-1:0]);
        end
      end
      S_PO_L: begin
        mem_re    = r_in;
        mem_raddr = heap_addr(side_r, r_idx[IW-1:0]);
      end
      S_PO_CMP: begin
        mem_we = 1'b1;
        if (!po_stay) mem_wdata = c_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // heap tops shadowed from the write port so the median needs no read
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == IW'(0)) lo_top_r <= mem_wdata;
    if (mem_we && mem_waddr == IW'(DEPTH - 1)) up_top_r <= mem_wdata;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? 32'(cap_r) : 32'd0;

  // final median for the result beat
  val_t               fin_med;
  logic signed [63:0] fin_m64;
  assign fin_med = (total == '0) ? '0 : ((lo_cnt_r == up_cnt_r) ? lo_top_r : up_top_r);
  assign fin_m64 = 64'(fin_med);

  // sequencer: planned pop, then up to two pushes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_cnt_r    <= '0;
      up_cnt_r    <= '0;
      need_pop_r  <= 1'b0;
      need_p1_r   <= 1'b0;
      need_p2_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT loads the result register itself
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            status_r   <= ST_OK;
            x_r        <= in_x;
            need_pop_r <= 1'b0;
            need_p1_r  <= 1'b0;
            need_p2_r  <= 1'b0;
            state_r    <= S_NEXT;
            if (in_tuser == CMD_INSERT) begin
              if (full) begin
                status_r <= ST_OVERFLOW;
              end else if (total == '0) begin
                need_p1_r <= 1'b1;
                pside_r   <= SIDE_UP;
              end else if (lo_cnt_r == up_cnt_r) begin
                need_p1_r <= 1'b1;
                if (in_x >= lo_top_r) begin
                  pside_r <= SIDE_UP;
                end else begin
                  // old lower top crosses to the upper heap
                  pside_r    <= SIDE_LO;
                  need_pop_r <= 1'b1;
                  need_p2_r  <= 1'b1;
                  med_r      <= lo_top_r;
                end
              end else begin
                need_p1_r <= 1'b1;
                if (in_x <= up_top_r) begin
                  pside_r <= SIDE_LO;
                end else begin
                  pside_r    <= SIDE_UP;
                  need_pop_r <= 1'b1;
                  need_p2_r  <= 1'b1;
                  med_r      <= up_top_r;
                end
              end
            end else begin
              if (total == '0) begin
                status_r <= ST_UNDERFLOW;
              end else begin
                need_pop_r <= 1'b1;
                pside_r    <= (lo_cnt_r == up_cnt_r) ? SIDE_LO : SIDE_UP;
              end
            end
          end
        end
        S_NEXT: begin
          if (need_pop_r) begin
            need_pop_r <= 1'b0;
            side_r     <= pside_r;
            n_r        <= pcnt - CW'(1);
            if (pside_r) up_cnt_r <= up_cnt_r - CW'(1);
            else         lo_cnt_r <= lo_cnt_r - CW'(1);
            if (pcnt > CW'(1)) state_r <= S_PO_LAST;
          end else if (need_p1_r) begin
            need_p1_r <= 1'b0;
            side_r    <= pside_r;
            v_r       <= x_r;
            i_r       <= IW'(pcnt);
            if (pside_r) up_cnt_r <= up_cnt_r + CW'(1);
            else         lo_cnt_r <= lo_cnt_r + CW'(1);
            state_r   <= S_PU_LOOP;
          end else if (need_p2_r) begin
            need_p2_r <= 1'b0;
            side_r    <= !pside_r;
            v_r       <= med_r;
            i_r       <= IW'(pocnt);
            if (pside_r) lo_cnt_r <= lo_cnt_r + CW'(1);
            else         up_cnt_r <= up_cnt_r + CW'(1);
            state_r   <= S_PU_LOOP;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_PU_LOOP: begin
          state_r <= (i_r == '0) ? S_NEXT : S_PU_CMP;
        end
        S_PU_CMP: begin
          if (pu_better) begin
            i_r     <= par_idx;
            state_r <= S_PU_LOOP;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_PO_LAST: begin
          v_r     <= rd_data_r;
          i_r     <= '0;
          state_r <= S_PO_LOOP;
        end
        S_PO_LOOP: begin
          state_r <= l_in ? S_PO_L : S_NEXT;
        end
        S_PO_L: begin
          c_r     <= rd_data_r;
          cidx_r  <= l_idx[IW-1:0];
          state_r <= r_in ? S_PO_R : S_PO_CMP;
        end
        S_PO_R: begin
          if (po_take_r) begin
            c_r    <= rd_data_r;
            cidx_r <= r_idx[IW-1:0];
          end
          state_r <= S_PO_CMP;
        end
        S_PO_CMP: begin
          if (po_stay) begin
            state_r <= S_NEXT;
          end else begin
            i_r     <= cidx_r;
            state_r <= S_PO_LOOP;
          end
        end
        S_OUT: begin
          // result register frees as the previous beat leaves
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_med_r   <= fin_m64[MED_W-1:0];
            out_mv_r    <= (total != '0);
            out_cnt_r   <= COUNT_W'(total);
            out_st_r    <= status_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_mv_r;
  assign out_tdata  = {3'b000, out_st_r, out_cnt_r, out_med_r};
endmodule
`default_nettype wire

// ===== sv/rmh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);
  import rmh_pkg::*;

  // a stalled result beat stays
  `RMH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // valid flag follows the count
  `RMH_ASSERT(a_mv_count, !out_tvalid || (out_tuser == (out_tdata[42:32] != 11'd0)))
  // empty store reports a zero median
  `RMH_ASSERT(a_empty_zero, !out_tvalid || out_tuser || (out_tdata[31:0] == 32'd0))
  // refused delete only on an empty store
  `RMH_ASSERT(a_unf_empty, !out_tvalid || (out_tdata[44:43] != ST_UNDERFLOW) || !out_tuser)
  // status is one of the three codes
  `RMH_ASSERT(a_status_code, !out_tvalid || (out_tdata[44:43] <= ST_UNDERFLOW))
endmodule

bind running_median_two_heaps_top rmh_checker u_rmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
